// ===== rtl/tws_pkg.sv =====
// Shared types and constants for the three-wire serial master.
// No dependencies; compiled first.
`default_nettype none

package tws_pkg;

  // mode field codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_FRAME_TICKS = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [7:0] FRAME_TICKS_RST = 8'd4;

  // command byte forcing: bit 0 clear for write, set for read
  localparam logic [7:0] CMD_WRITE_MASK = 8'hFE;
  localparam logic [7:0] CMD_READ_SET   = 8'h01;

  localparam int unsigned BYTE_BITS = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       io_in;
  } tws_req_t;

  typedef struct packed {
    logic       ce;
    logic       sclk;
    logic       io_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       done_res;
  } tws_res_t;

endpackage

`default_nettype wire

// ===== rtl/tws_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on nothing; field widths follow tws_pkg structs.
`default_nettype none

interface tws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       io_in;

  modport source (output valid, mode, reg_addr, write_data, io_in, input ready);
  modport sink   (input valid, mode, reg_addr, write_data, io_in, output ready);
endinterface

interface tws_res_if;
  logic       valid;
  logic       ready;
  logic       ce;
  logic       sclk;
  logic       io_drive;
  logic       busy_res;
  logic [7:0] read_data;
  logic       done_res;

  modport source (output valid, ce, sclk, io_drive, busy_res, read_data, done_res,
                  input ready);
  modport sink   (input valid, ce, sclk, io_drive, busy_res, read_data, done_res,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tws_seq.sv =====
// Phase sequencer of the three-wire master: state registers and next-state logic.
// Depends on tws_pkg.
`default_nettype none

module tws_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire tws_pkg::tws_req_t req_i,
  input  wire logic [7:0]        phase_ticks_i,
  input  wire logic [7:0]        frame_ticks_i,
  output tws_pkg::tws_res_t      res_o
);
  import tws_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PRE   = 4'd1,
    PH_CESU  = 4'd2,
    PH_SETUP = 4'd3,
    PH_HIGH  = 4'd4,
    PH_LOW   = 4'd5,
    PH_RHIGH = 4'd6,
    PH_RLOW  = 4'd7,
    PH_HOLD  = 4'd8,
    PH_GUARD = 4'd9
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  tick_q, tick_d;
  logic [4:0]  bit_q, bit_d;
  logic [15:0] shout_q, shout_d;
  logic [7:0]  shin_q, shin_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  rdata_q, rdata_d;

  logic [7:0] len;
  logic       last;
  logic       done;
  logic [7:0] sample;

  always_comb begin
    case (phase_q)
      PH_PRE, PH_CESU, PH_GUARD: len = frame_ticks_i;
      default:                   len = phase_ticks_i;
    endcase
  end

  // phase ends once count+1 reaches length; zero length acts as one
  assign last = ({1'b0, tick_q} + 9'd1) >= {1'b0, len};

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shout_d   = shout_q;
    shin_d    = shin_q;
    is_read_d = is_read_q;
    rdata_d   = rdata_q;
    done      = 1'b0;
    sample    = '0;
    if (step_i) begin
      case (req_i.mode)
        MODE_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (!last) begin
              tick_d = tick_q + 8'd1;
            end else begin
              tick_d = '0;
              case (phase_q)
                PH_PRE:   phase_d = PH_CESU;
                PH_CESU:  phase_d = PH_SETUP;
                PH_SETUP: phase_d = PH_HIGH;
                PH_HIGH:  phase_d = PH_LOW;
                PH_LOW: begin
                  shout_d = {1'b0, shout_q[15:1]};
                  bit_d   = bit_q + 5'd1;
                  if ({1'b0, bit_d} < (is_read_q ? 6'(BYTE_BITS) : 6'(2 * BYTE_BITS))) begin
                    phase_d = PH_SETUP;
                  end else if (is_read_q) begin
                    sample  = {7'b0, req_i.io_in} << bit_d[2:0];
                    shin_d  = shin_q | sample;
                    phase_d = PH_RHIGH;
                  end else begin
                    phase_d = PH_HOLD;
                  end
                end
                PH_RHIGH: phase_d = PH_RLOW;
                PH_RLOW: begin
                  bit_d = bit_q + 5'd1;
                  if ({1'b0, bit_d} < 6'(2 * BYTE_BITS)) begin
                    sample  = {7'b0, req_i.io_in} << bit_d[2:0];
                    shin_d  = shin_q | sample;
                    phase_d = PH_RHIGH;
                  end else begin
                    phase_d = PH_HOLD;
                  end
                end
                PH_HOLD:  phase_d = PH_GUARD;
                PH_GUARD: begin
                  if (is_read_q) rdata_d = shin_q;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
                default:  phase_d = PH_IDLE;
              endcase
            end
          end
        end
        MODE_WRITE, MODE_READ: begin
          if (phase_q == PH_IDLE) begin
            is_read_d = req_i.mode[0];
            shout_d   = (req_i.mode == MODE_WRITE)
                      ? {req_i.write_data, req_i.reg_addr & CMD_WRITE_MASK}
                      : {8'h00, req_i.reg_addr | CMD_READ_SET};
            shin_d    = '0;
            bit_d     = '0;
            tick_d    = '0;
            phase_d   = PH_PRE;
          end
        end
        default: ;
      endcase
    end
  end

  // line levels reflect the state after this item
  always_comb begin
    res_o.ce        = phase_d inside {PH_CESU, PH_SETUP, PH_HIGH, PH_LOW,
                                      PH_RHIGH, PH_RLOW, PH_HOLD};
    res_o.sclk      = (phase_d == PH_HIGH) || (phase_d == PH_RHIGH);
    res_o.io_drive  = (phase_d inside {PH_SETUP, PH_HIGH, PH_LOW}) ? shout_d[0] : 1'b1;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.read_data = rdata_d;
    res_o.done_res  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      shout_q   <= '0;
      shin_q    <= '0;
      is_read_q <= 1'b0;
      rdata_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shout_q   <= shout_d;
      shin_q    <= shin_d;
      is_read_q <= is_read_d;
      rdata_q   <= rdata_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/three_wire_serial_master_top.sv =====
// Top level of the three-wire serial master: config registers, handshake, result register.
// Depends on tws_pkg, tws_if and tws_seq.
//
// Usage:
//   req_i carries one item per transfer: a write request, a read request or a
//   tick that holds the sampled data line. Each tick advances the pin timing of
//   the current transaction by one step; requests while busy are dropped.
//   res_o returns exactly one transfer per request transfer, showing ce, sclk,
//   the data line drive, busy, the last read byte and a done flag.
//   Config: cfg_we_i writes cfg_data_i into phase_ticks (index 0) or
//   frame_ticks (index 1) on the clock edge; write only while idle.
// Result timing and throughput:
//   A result is registered and appears in the cycle after its request transfer.
//   The sequencer is combinational, so one item is taken per cycle while req_i.ready is high.
// Stall:
//   The result register holds a waiting result; req_i.ready stays high while
//   that register is empty or being drained in the same cycle, so a stalled
//   receiver stops intake only after one result is parked.
// Reset:
//   rst_ni clears the sequencer to idle, the read byte to zero, the result
//   register to empty and the timing registers to 2 and 4 ticks.
`default_nettype none

module three_wire_serial_master_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tws_req_if.sink         req_i,
  tws_res_if.source       res_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);
  import tws_pkg::*;

  logic [7:0] phase_ticks_q;
  logic [7:0] frame_ticks_q;

  logic     out_valid_q;
  tws_res_t out_q;
  tws_res_t res_d;
  tws_req_t req;
  logic     step;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  assign req.mode       = req_i.mode;
  assign req.reg_addr   = req_i.reg_addr;
  assign req.write_data = req_i.write_data;
  assign req.io_in      = req_i.io_in;

  tws_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .req_i         (req),
    .phase_ticks_i (phase_ticks_q),
    .frame_ticks_i (frame_ticks_q),
    .res_o         (res_d)
  );

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      frame_ticks_q <= FRAME_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        CFG_FRAME_TICKS: frame_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result register: valid flag reset, payload loads on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.ce        = out_q.ce;
  assign res_o.sclk      = out_q.sclk;
  assign res_o.io_drive  = out_q.io_drive;
  assign res_o.busy_res  = out_q.busy_res;
  assign res_o.read_data = out_q.read_data;
  assign res_o.done_res  = out_q.done_res;

endmodule

`default_nettype wire

// ===== rtl/tws_checker.sv =====
// Port-level checks for the three-wire serial master, bound to the top level.
// Depends on three_wire_serial_master_top.
`default_nettype none

module tws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       ce,
  input wire logic       sclk,
  input wire logic       io_drive,
  input wire logic       busy_res,
  input wire logic [7:0] read_data,
  input wire logic       done_res
);

  // a finished transaction leaves the link idle with ce low
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && done_res |-> !busy_res && !ce)
    else $error("done result with link still active");

  // clock pulses only inside a ce frame
  a_sclk_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && sclk |-> ce)
    else $error("sclk high outside ce frame");

  // idle link: ce and sclk low, data line released
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !busy_res |-> !ce && !sclk && io_drive)
    else $error("idle link lines not at rest");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(busy_res))
    else $error("stalled result changed");

endmodule

bind three_wire_serial_master_top tws_checker u_tws_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .ce        (res_o.ce),
  .sclk      (res_o.sclk),
  .io_drive  (res_o.io_drive),
  .busy_res  (res_o.busy_res),
  .read_data (res_o.read_data),
  .done_res  (res_o.done_res)
);

`default_nettype wire
